>>> design/upps_pkg.sv
`default_nettype none

package upps_pkg;

	// Receive queues that can have a socket bound
	localparam int unsigned QUEUE_COUNT = 64;

	// Frame byte offsets that are inspected
	localparam logic [5:0] OFS_TYPE_HI  = 6'd12;
	localparam logic [5:0] OFS_TYPE_LO  = 6'd13;
	localparam logic [5:0] OFS_PROTO    = 6'd23;
	localparam logic [5:0] OFS_PORT_HI  = 6'd36;
	localparam logic [5:0] OFS_PORT_LO  = 6'd37;
	localparam logic [5:0] SAT_POS      = 6'd42;

	// Offset of the last byte from which a frame is long enough for each check
	localparam logic [5:0] SHORT_ETH    = 6'd13;
	localparam logic [5:0] SHORT_IP     = 6'd33;
	localparam logic [5:0] SHORT_UDP    = 6'd41;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [15:0] RESET_PORT     = 16'd5000;

	// Configuration register indexes
	localparam logic [1:0] REG_TARGET_PORT = 2'd0;
	localparam logic [1:0] REG_SOCKET_MASK = 2'd1;

	typedef enum logic [2:0] {
		REASON_REDIRECT   = 3'd0,
		REASON_TOO_SHORT  = 3'd1,
		REASON_NOT_IPV4   = 3'd2,
		REASON_NOT_UDP    = 3'd3,
		REASON_PORT_MISS  = 3'd4,
		REASON_NO_SOCKET  = 3'd5
	} reason_t;

	typedef struct packed {
		logic [15:0] steer_port;
		logic [63:0] socket_mask;
	} cfg_t;

	typedef struct packed {
		logic       redirect;
		logic [5:0] target_queue;
		reason_t    reason;
	} verdict_t;

endpackage

`default_nettype wire

>>> design/udp_port_packet_steering_core.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: data_byte, tlast, tuser: queue_index
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: target_queue, reason; tuser: redirect
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One byte is accepted per cycle while no last byte is held back. A byte goes
// to an input register, the verdict logic (offset compares and one 16-bit port
// compare) sits between that register and the output register, so the verdict
// word is loaded as the last byte leaves the input register. Mid-frame bytes
// keep moving while a verdict waits in the output register; only a last byte
// stalls behind it. Reset clears frame state, both valids and loads port 5000, mask 0.
`default_nettype none

module udp_port_packet_steering_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tlast,
	input  wire logic [7:0]  s_axis_tuser,   // [7:0] queue_index
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [5:0] target_queue, [8:6] reason, [15:9] zero
	output logic             m_axis_tuser,   // [0] redirect
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	logic [7:0]         queue_s1;
	logic               advance;
	logic               step;
	logic               out_valid_q;
	upps_pkg::verdict_t verdict;
	upps_pkg::verdict_t verdict_q;
	upps_pkg::cfg_t     cfg;

	assign cfg_ready = 1'b1;

	upps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// A last byte moves on only if the output register is free or draining
	assign advance       = !last_s1 || !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			last_s1  <= s_axis_tlast;
			queue_s1 <= s_axis_tuser;
		end
	end

	upps_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.data_byte   (byte_s1),
		.last_byte   (last_s1),
		.queue_index (queue_s1),
		.cfg         (cfg),
		.verdict     (verdict)
	);

	// Output register: load a verdict word, hold it until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step && last_s1)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && last_s1)
			verdict_q <= verdict;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = verdict_q.redirect;
	assign m_axis_tdata  = {7'd0, verdict_q.reason, verdict_q.target_queue};

	// A new verdict only follows a last byte
	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(step && last_s1))
		else $error("verdict word without a last byte");

	// Redirect and reason agree
	a_redirect_reason: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[8:6] == upps_pkg::REASON_REDIRECT)))
		else $error("redirect flag disagrees with reason");

	// A passed frame names no queue
	a_pass_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[5:0] == 6'd0))
		else $error("passed frame carries a queue");

	// The output register is never overwritten while a word waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !(step && last_s1))
		else $error("pending verdict overwritten");

endmodule

`default_nettype wire

>>> design/upps_cfg.sv
`default_nettype none

module upps_cfg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire logic [1:0]      wr_index,
	input  wire logic [63:0]     wr_data,
	output upps_pkg::cfg_t       cfg
);

	logic [15:0] steer_port_q;
	logic [63:0] socket_mask_q;

	// Write a register; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_port_q  <= upps_pkg::RESET_PORT;
			socket_mask_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				upps_pkg::REG_TARGET_PORT: steer_port_q <= wr_data[15:0];
				upps_pkg::REG_SOCKET_MASK: socket_mask_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg.steer_port  = steer_port_q;
	assign cfg.socket_mask = socket_mask_q;

endmodule

`default_nettype wire

>>> design/upps_frame.sv
`default_nettype none

module upps_frame (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      data_byte,
	input  wire logic            last_byte,
	input  wire logic [7:0]      queue_index,
	input  wire upps_pkg::cfg_t  cfg,
	output upps_pkg::verdict_t   verdict
);

	logic [5:0] pos_q;
	logic [7:0] type_hi_q;
	logic       is_ipv4_q;
	logic       is_udp_q;
	logic [7:0] port_hi_q;
	logic       port_match_q;

	logic [5:0] pos_n;
	logic [7:0] type_hi_n;
	logic       is_ipv4_n;
	logic       is_udp_n;
	logic [7:0] port_hi_n;
	logic       port_match_n;
	logic       socket_ok;

	// Capture header fields at their offsets
	always_comb begin
		type_hi_n    = type_hi_q;
		is_ipv4_n    = is_ipv4_q;
		is_udp_n     = is_udp_q;
		port_hi_n    = port_hi_q;
		port_match_n = port_match_q;
		case (pos_q)
			upps_pkg::OFS_TYPE_HI: type_hi_n = data_byte;
			upps_pkg::OFS_TYPE_LO: is_ipv4_n = ({type_hi_q, data_byte} == upps_pkg::ETHERTYPE_IPV4);
			upps_pkg::OFS_PROTO:   is_udp_n  = (data_byte == upps_pkg::PROTO_UDP);
			upps_pkg::OFS_PORT_HI: port_hi_n = data_byte;
			upps_pkg::OFS_PORT_LO: port_match_n = ({port_hi_q, data_byte} == cfg.steer_port);
			default: ;
		endcase
		pos_n = (pos_q < upps_pkg::SAT_POS) ? pos_q + 6'd1 : pos_q;
	end

	assign socket_ok = (queue_index < 8'(upps_pkg::QUEUE_COUNT)) &&
		cfg.socket_mask[queue_index[5:0]];

	// Decide in frame order
	always_comb begin
		verdict.redirect     = 1'b0;
		verdict.target_queue = '0;
		if (pos_q < upps_pkg::SHORT_ETH)
			verdict.reason = upps_pkg::REASON_TOO_SHORT;
		else if (!is_ipv4_n)
			verdict.reason = upps_pkg::REASON_NOT_IPV4;
		else if (pos_q < upps_pkg::SHORT_IP)
			verdict.reason = upps_pkg::REASON_TOO_SHORT;
		else if (!is_udp_n)
			verdict.reason = upps_pkg::REASON_NOT_UDP;
		else if (pos_q < upps_pkg::SHORT_UDP)
			verdict.reason = upps_pkg::REASON_TOO_SHORT;
		else if (!port_match_n)
			verdict.reason = upps_pkg::REASON_PORT_MISS;
		else if (socket_ok) begin
			verdict.reason       = upps_pkg::REASON_REDIRECT;
			verdict.redirect     = 1'b1;
			verdict.target_queue = queue_index[5:0];
		end else
			verdict.reason = upps_pkg::REASON_NO_SOCKET;
	end

	// Advance frame state; clear after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			type_hi_q    <= '0;
			is_ipv4_q    <= 1'b0;
			is_udp_q     <= 1'b0;
			port_hi_q    <= '0;
			port_match_q <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				pos_q        <= '0;
				type_hi_q    <= '0;
				is_ipv4_q    <= 1'b0;
				is_udp_q     <= 1'b0;
				port_hi_q    <= '0;
				port_match_q <= 1'b0;
			end else begin
				pos_q        <= pos_n;
				type_hi_q    <= type_hi_n;
				is_ipv4_q    <= is_ipv4_n;
				is_udp_q     <= is_udp_n;
				port_hi_q    <= port_hi_n;
				port_match_q <= port_match_n;
			end
		end
	end

endmodule

`default_nettype wire

>>> bench/tb_udp_port_packet_steering_core.sv
`timescale 1ns / 100ps

module tb_udp_port_packet_steering_core;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;

	// Register indexes past the list; writes to them must change nothing
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;

	localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
	logic        s_axis_tlast = 1'b0;
	logic [7:0]  s_axis_tuser = '0;   // [7:0] queue_index
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // [5:0] target_queue, [8:6] reason, [15:9] zero
	logic        m_axis_tuser;        // [0] redirect
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// Steering predictor state and its copy of the registers
	logic [5:0]  frm_pos;
	logic [7:0]  type_hi;
	logic        ipv4_ok;
	logic        udp_ok;
	logic [7:0]  port_hi;
	logic        port_hit;
	logic [15:0] cur_port;
	logic [63:0] cur_mask;

	upps_pkg::verdict_t pending_verdicts[$];
	int          err_count = 0;
	int          cycle_count = 0;
	int          rx_hold_req = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;

	udp_port_packet_steering_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Clear per-frame tracking
	task automatic clear_frame_state();
		frm_pos  = '0;
		type_hi  = '0;
		ipv4_ok  = 1'b0;
		udp_ok   = 1'b0;
		port_hi  = '0;
		port_hit = 1'b0;
	endtask

	// Advance the steering predictor by one accepted word
	task automatic steer_predict(input logic [7:0] data, input logic last,
			input logic [7:0] q);
		logic [5:0]         pos;
		upps_pkg::verdict_t v;
		pos = frm_pos;
		case (pos)
			upps_pkg::OFS_TYPE_HI: type_hi = data;
			upps_pkg::OFS_TYPE_LO: ipv4_ok = ({type_hi, data} == upps_pkg::ETHERTYPE_IPV4);
			upps_pkg::OFS_PROTO:   udp_ok = (data == upps_pkg::PROTO_UDP);
			upps_pkg::OFS_PORT_HI: port_hi = data;
			upps_pkg::OFS_PORT_LO: port_hit = ({port_hi, data} == cur_port);
			default: ;
		endcase
		if (pos < upps_pkg::SAT_POS)
			frm_pos = pos + 6'd1;
		if (last) begin
			v.redirect = 1'b0;
			v.target_queue = '0;
			// Checks in frame order
			if (pos < upps_pkg::SHORT_ETH)
				v.reason = upps_pkg::REASON_TOO_SHORT;
			else if (!ipv4_ok)
				v.reason = upps_pkg::REASON_NOT_IPV4;
			else if (pos < upps_pkg::SHORT_IP)
				v.reason = upps_pkg::REASON_TOO_SHORT;
			else if (!udp_ok)
				v.reason = upps_pkg::REASON_NOT_UDP;
			else if (pos < upps_pkg::SHORT_UDP)
				v.reason = upps_pkg::REASON_TOO_SHORT;
			else if (!port_hit)
				v.reason = upps_pkg::REASON_PORT_MISS;
			else if (q < upps_pkg::QUEUE_COUNT && cur_mask[q[5:0]]) begin
				v.reason = upps_pkg::REASON_REDIRECT;
				v.redirect = 1'b1;
				v.target_queue = q[5:0];
			end else
				v.reason = upps_pkg::REASON_NO_SOCKET;
			pending_verdicts.push_back(v);
			clear_frame_state();
		end
	endtask

	// Track accepted input words
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			steer_predict(s_axis_tdata, s_axis_tlast, s_axis_tuser);
	end

	// Track register writes
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				upps_pkg::REG_TARGET_PORT: cur_port = cfg_data[15:0];
				upps_pkg::REG_SOCKET_MASK: cur_mask = cfg_data;
				default: ;
			endcase
		end
	end

	// Compare each verdict word against the oldest prediction
	always @(posedge clk) begin
		upps_pkg::verdict_t v;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected verdict word tdata %h tuser %b", $time,
					m_axis_tdata, m_axis_tuser);
				err_count++;
			end else begin
				v = pending_verdicts.pop_front();
				if (m_axis_tuser !== v.redirect) begin
					$display("%0t: redirect expected %0d actual %0d", $time,
						v.redirect, m_axis_tuser);
					err_count++;
				end
				if (m_axis_tdata[5:0] !== v.target_queue) begin
					$display("%0t: target_queue expected %0d actual %0d", $time,
						v.target_queue, m_axis_tdata[5:0]);
					err_count++;
				end
				if (m_axis_tdata[8:6] !== v.reason) begin
					$display("%0t: reason expected %0d actual %0d", $time,
						v.reason, m_axis_tdata[8:6]);
					err_count++;
				end
				if (m_axis_tdata[15:9] !== 7'd0) begin
					$display("%0t: tdata pad expected 0 actual %h", $time,
						m_axis_tdata[15:9]);
					err_count++;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				n = rx_hold_req;
				rx_hold_req = 0;
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end else
				m_axis_tready <= 1'b1;
		end
	end

	// Send one word; valid stays high for the caller's next word
	task automatic send_byte(input logic [7:0] data, input logic last,
			input logic [7:0] q);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tlast  <= last;
		s_axis_tuser  <= q;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Send a frame of random bytes with the inspected fields forced
	task automatic send_frame(input int len, input logic [7:0] q,
			input logic [15:0] etype, input logic [7:0] proto, input logic [15:0] port);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			case (i)
				upps_pkg::OFS_TYPE_HI: b = etype[15:8];
				upps_pkg::OFS_TYPE_LO: b = etype[7:0];
				upps_pkg::OFS_PROTO:   b = proto;
				upps_pkg::OFS_PORT_HI: b = port[15:8];
				upps_pkg::OFS_PORT_LO: b = port[7:0];
				default: ;
			endcase
			send_byte(b, i == len - 1, q);
		end
	endtask

	// Hold the sender until every verdict is in and the pipeline is empty
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; valid is left high for a following write
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [15:0] port, input logic [63:0] mask);
		wait_idle();
		write_reg(upps_pkg::REG_TARGET_PORT, {48'($urandom), port});
		write_reg(upps_pkg::REG_SOCKET_MASK, mask);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed UDP frames with random content
	task automatic send_random_frame();
		int len;
		int r;
		logic [7:0]  q;
		logic [15:0] etype;
		logic [7:0]  proto;
		logic [15:0] port;
		r = $urandom_range(0, 99);
		if (r < 30)
			len = $urandom_range(1, 41);
		else if (r < 80)
			len = $urandom_range(42, 48);
		else
			len = $urandom_range(49, 90);
		q = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 63)) : 8'($urandom);
		etype = ($urandom_range(0, 9) < 8) ? upps_pkg::ETHERTYPE_IPV4 : 16'($urandom);
		proto = ($urandom_range(0, 9) < 8) ? upps_pkg::PROTO_UDP : 8'($urandom);
		r = $urandom_range(0, 9);
		if (r < 6)
			port = cur_port;
		else if (r < 8)
			port = cur_port ^ (16'd1 << $urandom_range(0, 15));
		else
			port = 16'($urandom);
		send_frame(len, q, etype, proto, port);
	endtask

	// Reset values: port 5000 matches but no socket is bound
	task automatic test_reset_defaults();
		send_frame(42, 8'd0, upps_pkg::ETHERTYPE_IPV4, upps_pkg::PROTO_UDP,
			upps_pkg::RESET_PORT);
		wait_idle();
	endtask

	// Each verdict reason at the length boundaries of the checks
	task automatic test_check_order();
		logic [15:0] port;
		port = 16'h1234;
		set_config(port, 64'h8000_0000_0000_0020);
		send_frame(1, 8'd5, upps_pkg::ETHERTYPE_IPV4, upps_pkg::PROTO_UDP, port);
		send_frame(13, 8'd5, upps_pkg::ETHERTYPE_IPV4, upps_pkg::PROTO_UDP, port);
		send_frame(14, 8'd5, ETHERTYPE_IPV6, upps_pkg::PROTO_UDP, port);
		send_frame(14, 8'd5, upps_pkg::ETHERTYPE_IPV4, upps_pkg::PROTO_UDP, port);
		send_frame(34, 8'd5, upps_pkg::ETHERTYPE_IPV4, PROTO_TCP, port);
		send_frame(41, 8'd5, upps_pkg::ETHERTYPE_IPV4, upps_pkg::PROTO_UDP, port);
		send_frame(42, 8'd5, upps_pkg::ETHERTYPE_IPV4, upps_pkg::PROTO_UDP,
			port ^ 16'h0100);
		// long frame: position saturates, verdict unchanged
		send_frame(46, 8'd5, upps_pkg::ETHERTYPE_IPV4, upps_pkg::PROTO_UDP, port);
		// queue beyond the socket range has no socket, even where bit 5 is set
		send_frame(42, 8'd69, upps_pkg::ETHERTYPE_IPV4, upps_pkg::PROTO_UDP, port);
		wait_idle();
	endtask

	// Register extremes
	task automatic test_register_extremes();
		set_config(16'h0000, '1);
		send_frame(42, 8'd63, upps_pkg::ETHERTYPE_IPV4, upps_pkg::PROTO_UDP, 16'h0000);
		set_config(16'hFFFF, 64'h8000_0000_0000_0001);
		send_frame(42, 8'd62, upps_pkg::ETHERTYPE_IPV4, upps_pkg::PROTO_UDP, 16'hFFFF);
		wait_idle();
	endtask

	// Writes past the register list leave the settings alone
	task automatic test_unused_registers();
		wait_idle();
		write_reg(upps_pkg::REG_TARGET_PORT, {48'($urandom), 16'hA55A});
		write_reg(upps_pkg::REG_SOCKET_MASK, 64'h5555_5555_5555_5555);
		write_reg(REG_SPARE_A, {$urandom, $urandom});
		write_reg(REG_SPARE_B, {$urandom, $urandom});
		cfg_valid <= 1'b0;
		send_frame(42, 8'd2, upps_pkg::ETHERTYPE_IPV4, upps_pkg::PROTO_UDP, 16'hA55A);
		wait_idle();
	endtask

	// Long receiver hold-off while short frames keep arriving
	task automatic test_output_stall();
		tx_idle_on = 1'b0;
		rx_hold_req = HOLD_CYCLES;
		for (int i = 0; i < 10; i++)
			send_frame($urandom_range(1, 3), 8'($urandom), upps_pkg::ETHERTYPE_IPV4,
				upps_pkg::PROTO_UDP, cur_port);
		wait_idle();
		tx_idle_on = 1'b1;
	endtask

	// Random frames over two register settings
	task automatic test_random_traffic();
		logic [15:0] port;
		logic [63:0] mask;
		int r;
		for (int ph = 0; ph < 2; ph++) begin
			r = $urandom_range(0, 9);
			port = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
			r = $urandom_range(0, 9);
			mask = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom};
			set_config(port, mask);
			// one phase runs without any idling on either side
			tx_idle_on = (ph != 1);
			rx_idle_on = (ph != 1);
			for (int f = 0; f < 2; f++) begin
				send_random_frame();
				if ($urandom_range(0, 9) == 0)
					wait_idle();
			end
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		wait_idle();
	endtask

	// Test sequence
	initial begin
		cur_port = upps_pkg::RESET_PORT;
		cur_mask = '0;
		clear_frame_state();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_check_order();
		test_register_extremes();
		test_unused_registers();
		test_output_stall();
		test_random_traffic();
		wait_idle();
		if (err_count == 0 && pending_verdicts.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
